// ----- hdl/gtg_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, codes and constant tables for the go-to-goal heading controller.
// No dependencies; imported by the top level.
package gtg_pkg;

    localparam int POS_W      = 24;
    localparam int YAW_W      = 16;
    localparam int RATE_W     = 14;
    localparam int RAD_W      = 16;
    localparam int HEL_W      = 15;
    localparam int SPD_W      = 13;
    localparam int ANG_W      = 15;
    localparam int HC_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // difference of two positions, and CORDIC x/y with room for the gain
    localparam int DIFF_W = POS_W + 1;
    localparam int CW     = POS_W + 3;
    // Q30 angle accumulator, holds +/- (pi + sum of all table entries)
    localparam int ZW     = 34;

    localparam int TABLE_LEN = 24;
    localparam int ITER_W    = $clog2(TABLE_LEN);
    localparam int MUL_W     = RAD_W;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_EVAL,
        ST_ERR,
        ST_WRAP,
        ST_CLAMP,
        ST_OUT
    } state_t;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One step of a shift-add multiplier: the low half holds the remaining
    // multiplier bits, the high half the partial product.
    function automatic logic [2*MUL_W-1:0] mul_step(input logic [2*MUL_W-1:0] acc,
                                                   input logic [MUL_W-1:0]   mcand);
        logic [MUL_W:0] sum;
        sum = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);
        return {sum, acc[MUL_W-1:1]};
    endfunction

endpackage

// ----- hdl/go_to_goal_heading_controller.sv -----
`timescale 1ns / 1ps
// A request runs PREP, the ITER steps and EVAL, then, unless arrived, ERR, WRAP and CLAMP,
// with WRAP repeated for each extra 2*pi fold (at most one at the default angle format),
// and ends in OUT. One request at a time, taken the cycle after the result is loaded;
// the result waits in OUT while the output holds a previous one that is not yet taken.
// The shared CORDIC stage and the three bit-serial 16x16 squarers set ITERS.
// Reset: registers at their documented defaults, heading command zero, no result held.
module go_to_goal_heading_controller #(
    parameter int CORDIC_STEPS    = gtg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = gtg_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [gtg_pkg::POS_W-1:0]       robot_x,
    input  logic signed [gtg_pkg::POS_W-1:0]       robot_y,
    input  logic signed [gtg_pkg::YAW_W-1:0]       robot_yaw,
    input  logic signed [gtg_pkg::POS_W-1:0]       goal_x,
    input  logic signed [gtg_pkg::POS_W-1:0]       goal_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [gtg_pkg::SPD_W-1:0]              linear_speed,
    output logic signed [gtg_pkg::ANG_W-1:0]       angular_rate,
    output logic                                   arrived
);
    import gtg_pkg::*;

    localparam int S     = 30 - ANGLE_FRAC_BITS;
    localparam int BW    = ZW - S;
    localparam int EW    = ((ANGLE_FRAC_BITS + 3 > YAW_W) ? ANGLE_FRAC_BITS + 3 : YAW_W) + 3;
    localparam int ITERS = (CORDIC_STEPS > MUL_W) ? CORDIC_STEPS : MUL_W;

    localparam longint PI_F_L     = (PI_Q30 + (64'sd1 <<< (S - 1))) >>> S;
    localparam longint TWO_PI_F_L = (TWO_PI_Q30 + (64'sd1 <<< (S - 1))) >>> S;

    localparam logic signed [EW-1:0] PI_F     = EW'(PI_F_L);
    localparam logic signed [EW-1:0] TWO_PI_F = EW'(TWO_PI_F_L);
    localparam logic signed [ZW-1:0] PI_Z     = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] HALF_Z   = ZW'(64'sd1 <<< (S - 1));

    localparam logic [ITER_W-1:0] LAST_STEP  = ITER_W'(ITERS - 1);
    localparam logic [ITER_W-1:0] CORDIC_END = ITER_W'(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] MUL_END    = ITER_W'(MUL_W);

    state_t state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    logic [RATE_W-1:0] max_turn_rate_reg, max_turn_rate_next;
    logic [RAD_W-1:0]  arrival_radius_reg, arrival_radius_next;
    logic [HEL_W-1:0]  heading_error_limit_reg, heading_error_limit_next;
    logic [SPD_W-1:0]  cruise_speed_reg, cruise_speed_next;
    logic [SPD_W-1:0]  slow_speed_reg, slow_speed_next;

    logic signed [HC_W-1:0] hc_reg, hc_next;
    logic out_valid_reg, out_valid_next;

    logic signed [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [YAW_W-1:0]  yaw_reg, yaw_next;
    logic signed [CW-1:0]     x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    logic                     zero_reg, zero_next, big_reg, big_next;
    logic [2*MUL_W-1:0]       sqx_reg, sqx_next, sqy_reg, sqy_next, sqr_reg, sqr_next;
    logic [MUL_W-1:0]         mcx_reg, mcx_next, mcy_reg, mcy_next, mcr_reg, mcr_next;
    logic                     arr_reg, arr_next;
    logic signed [EW-1:0]     e_reg, e_next;
    logic [SPD_W-1:0]         speed_reg, speed_next;
    logic signed [ANG_W-1:0]  rate_reg, rate_next;
    logic                     arrived_reg, arrived_next;

    // combinational helpers
    logic [DIFF_W-1:0]        adx, ady;
    logic signed [CW-1:0]     x_ext, y_ext, xs, ys;
    logic signed [ZW-1:0]     at, zr;
    logic signed [BW-1:0]     bear;
    logic [2*MUL_W:0]         d2;
    logic signed [EW-1:0]     g, lim_e;
    logic [EW-1:0]            mag;
    logic                     load_out;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign linear_speed = speed_reg;
    assign angular_rate = rate_reg;
    assign arrived      = arrived_reg;

    always_comb
    begin
        state_next               = state_reg;
        cnt_next                 = cnt_reg;
        max_turn_rate_next       = max_turn_rate_reg;
        arrival_radius_next      = arrival_radius_reg;
        heading_error_limit_next = heading_error_limit_reg;
        cruise_speed_next        = cruise_speed_reg;
        slow_speed_next          = slow_speed_reg;
        hc_next                  = hc_reg;
        dx_next                  = dx_reg;
        dy_next                  = dy_reg;
        yaw_next                 = yaw_reg;
        x_next                   = x_reg;
        y_next                   = y_reg;
        z_next                   = z_reg;
        zero_next                = zero_reg;
        big_next                 = big_reg;
        sqx_next                 = sqx_reg;
        sqy_next                 = sqy_reg;
        sqr_next                 = sqr_reg;
        mcx_next                 = mcx_reg;
        mcy_next                 = mcy_reg;
        mcr_next                 = mcr_reg;
        arr_next                 = arr_reg;
        e_next                   = e_reg;
        speed_next               = speed_reg;
        rate_next                = rate_reg;
        arrived_next             = arrived_reg;
        load_out                 = 1'b0;

        adx   = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        ady   = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        x_ext = CW'(dx_reg);
        y_ext = CW'(dy_reg);
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        at    = signed'(ZW'(atan_q30(cnt_reg)));
        zr    = z_reg + HALF_Z;
        bear  = zr[ZW-1:S];
        d2    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        lim_e = signed'(EW'(max_turn_rate_reg));
        g     = EW'(hc_reg) + e_reg;
        mag   = e_reg[EW-1] ? EW'(-e_reg) : EW'(e_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_TURN:  max_turn_rate_next       = cfg_data[RATE_W-1:0];
                REG_ARRIVAL:   arrival_radius_next      = cfg_data[RAD_W-1:0];
                REG_ERR_LIMIT: heading_error_limit_next = cfg_data[HEL_W-1:0];
                REG_CRUISE:    cruise_speed_next        = cfg_data[SPD_W-1:0];
                REG_SLOW:      slow_speed_next          = cfg_data[SPD_W-1:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dx_next    = {goal_x[POS_W-1], goal_x} - {robot_x[POS_W-1], robot_x};
                    dy_next    = {goal_y[POS_W-1], goal_y} - {robot_y[POS_W-1], robot_y};
                    yaw_next   = robot_yaw;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // fold a left-half vector into the right half by a turn of pi
                if (dx_reg[DIFF_W-1])
                begin
                    x_next = -x_ext;
                    y_next = -y_ext;
                    z_next = dy_reg[DIFF_W-1] ? -PI_Z : PI_Z;
                end
                else
                begin
                    x_next = x_ext;
                    y_next = y_ext;
                    z_next = '0;
                end
                zero_next  = (dx_reg == '0) && (dy_reg == '0);
                // beyond 16 bits on either axis the distance exceeds any radius
                big_next   = (|adx[DIFF_W-1:MUL_W]) || (|ady[DIFF_W-1:MUL_W]);
                mcx_next   = adx[MUL_W-1:0];
                mcy_next   = ady[MUL_W-1:0];
                mcr_next   = arrival_radius_reg;
                sqx_next   = {{MUL_W{1'b0}}, adx[MUL_W-1:0]};
                sqy_next   = {{MUL_W{1'b0}}, ady[MUL_W-1:0]};
                sqr_next   = {{MUL_W{1'b0}}, arrival_radius_reg};
                cnt_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (cnt_reg < CORDIC_END)
                begin
                    if (!y_reg[CW-1])
                    begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + at;
                    end
                    else
                    begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - at;
                    end
                end
                if (cnt_reg < MUL_END)
                begin
                    sqx_next = mul_step(sqx_reg, mcx_reg);
                    sqy_next = mul_step(sqy_reg, mcy_reg);
                    sqr_next = mul_step(sqr_reg, mcr_reg);
                end
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                arr_next   = !big_reg && (d2 < {1'b0, sqr_reg});
                e_next     = zero_reg ? '0 : EW'(bear);
                state_next = (!big_reg && (d2 < {1'b0, sqr_reg})) ? ST_OUT : ST_ERR;
            end
            ST_ERR:
            begin
                e_next     = e_reg - EW'(yaw_reg) - EW'(hc_reg);
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                priority if (e_reg > TWO_PI_F)
                begin
                    e_next = e_reg - TWO_PI_F;
                end
                else if (e_reg < -TWO_PI_F)
                begin
                    e_next = e_reg + TWO_PI_F;
                end
                else
                begin
                    if (e_reg > PI_F)
                    begin
                        e_next = e_reg - TWO_PI_F;
                    end
                    else if (e_reg < -PI_F)
                    begin
                        e_next = e_reg + TWO_PI_F;
                    end
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                priority if (g > lim_e)
                begin
                    hc_next = HC_W'(lim_e);
                end
                else if (g < -lim_e)
                begin
                    hc_next = HC_W'(-lim_e);
                end
                else
                begin
                    hc_next = g[HC_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the result slot is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    if (arr_reg)
                    begin
                        speed_next = '0;
                        rate_next  = '0;
                    end
                    else
                    begin
                        speed_next = (mag > EW'(heading_error_limit_reg)) ? slow_speed_reg
                                                                          : cruise_speed_reg;
                        rate_next  = hc_reg[ANG_W-1:0];
                    end
                    arrived_next = arr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= ST_IDLE;
            cnt_reg                 <= '0;
            max_turn_rate_reg       <= RATE_W'(4096);
            arrival_radius_reg      <= RAD_W'(655);
            heading_error_limit_reg <= HEL_W'(1638);
            cruise_speed_reg        <= SPD_W'(1638);
            slow_speed_reg          <= SPD_W'(819);
            hc_reg                  <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            state_reg               <= state_next;
            cnt_reg                 <= cnt_next;
            max_turn_rate_reg       <= max_turn_rate_next;
            arrival_radius_reg      <= arrival_radius_next;
            heading_error_limit_reg <= heading_error_limit_next;
            cruise_speed_reg        <= cruise_speed_next;
            slow_speed_reg          <= slow_speed_next;
            hc_reg                  <= hc_next;
            out_valid_reg           <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        yaw_reg     <= yaw_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zero_reg    <= zero_next;
        big_reg     <= big_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sqr_reg     <= sqr_next;
        mcx_reg     <= mcx_next;
        mcy_reg     <= mcy_next;
        mcr_reg     <= mcr_next;
        arr_reg     <= arr_next;
        e_reg       <= e_next;
        speed_reg   <= speed_next;
        rate_reg    <= rate_next;
        arrived_reg <= arrived_next;
    end

    a_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAMP) |-> (e_reg <= PI_F && e_reg >= -PI_F))
        else $error("heading error not folded into [-pi, pi]");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAMP) |=>
            (EW'(hc_reg) <= lim_e && EW'(hc_reg) >= -lim_e))
        else $error("turn command outside the rate clamp");

    a_arrive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && arr_reg) |-> $stable(hc_reg))
        else $error("turn command changed on an arrived request");

    a_arrive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && arrived) |-> (linear_speed == '0 && angular_rate == '0))
        else $error("arrived result carries non-zero speeds");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP && !in_ready))
        else $error("request taken while another is in flight");

endmodule
